// File: rtl/rcii_pkg.sv
// ----------------------------------------------------------------------------
// rcii_pkg
// Shared types and constants for the rate curve interpolate/integrate core.
// ----------------------------------------------------------------------------
package rcii_pkg;

  localparam int unsigned TBL_AW    = 8;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned AREA_W    = 35;
  localparam int unsigned SPREAD_W  = 33;
  localparam int unsigned TIME_W    = 19;
  localparam int unsigned IN_DW     = 64;
  localparam int unsigned OUT_DW    = 104;

  localparam logic signed [RATE_W-1:0] ONE_Q24   = 32'sh0100_0000;
  localparam logic [TIME_W-1:0]        FIVE_Q16  = 19'd327680;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                     we;
    logic                     re;
    logic [TBL_AW-1:0]        waddr;
    logic [TBL_AW-1:0]        raddr;
    logic signed [RATE_W-1:0] wdata;
  } tbl_req_t;

endpackage

// File: rtl/rcii_table.sv
// ----------------------------------------------------------------------------
// rcii_table
// Curve point memory, one write and one registered read a cycle. Entries not
// yet written read as 1.0.
// ----------------------------------------------------------------------------
module rcii_table #(
  parameter int unsigned DEPTH = 69
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rcii_pkg::tbl_req_t               req_i,
  output logic signed [rcii_pkg::RATE_W-1:0] rdata_o
);
  import rcii_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [RATE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         vld_q;
  logic signed [RATE_W-1:0] rdata_q;
  logic                     rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[AW-1:0]];
      rvld_q  <= vld_q[req_i.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr[AW-1:0]] <= 1'b1;
    end
  end

  assign rdata_o = rvld_q ? rdata_q : ONE_Q24;

endmodule

// File: rtl/rate_curve_interp_integrate_core.sv
// ----------------------------------------------------------------------------
// rate_curve_interp_integrate_core
// Yield curve store: point loads, interpolated rate, trapezoid integral and
// spread against curve 0, all from one point memory.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                                | tuser
//  s_axis   | in  | curve_select, point_index, point_value, query_time| kind
//  m_axis   | out | rate_value, area_value, spread_value              | -
//
//  Load: from accept to the done step, which fills the result register once
//  the output is free. Query: 4 + (i + 1) memory reads then 4 arithmetic
//  steps; i is the quarter index of the clamped time, and the single read
//  port of the point memory takes the reads one after another.
//  Reset clears control and valid bits only; no clearing pass.
//  A waiting result does not block the next accept; a second result waits
//  in the done step until the output word is taken.
// ----------------------------------------------------------------------------
module rate_curve_interp_integrate_core #(
  parameter int unsigned POINTS = 23,
  parameter int unsigned CURVES = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // curve_select[1:0], point_index[6:2], point_value[38:7], query_time[57:39]
  input  logic [rcii_pkg::IN_DW-1:0]       s_axis_tdata_i,
  // kind[0]
  input  logic [0:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // rate_value[31:0], area_value[66:32], spread_value[99:67]
  output logic [rcii_pkg::OUT_DW-1:0]      m_axis_tdata_o
);
  import rcii_pkg::*;

  localparam int unsigned IW    = $clog2(POINTS);
  localparam int unsigned DEPTH = CURVES * POINTS;
  localparam int unsigned SUM_W = 38;
  localparam int unsigned PRD_W = 48;
  localparam int unsigned TOT_W = 53;
  localparam int unsigned CNT_W = 5;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_M1   = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_M3   = 3'd4;
  localparam logic [2:0] S_M4   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  function automatic logic [IW-1:0] sat_pt(input logic [5:0] k);
    if (int'(k) >= int'(POINTS)) begin
      return IW'(POINTS - 1);
    end
    return IW'(k);
  endfunction

  function automatic logic [TBL_AW-1:0] addr_of(input logic [1:0] c, input logic [5:0] k);
    return TBL_AW'(c) * TBL_AW'(POINTS) + TBL_AW'(sat_pt(k));
  endfunction

  logic [2:0]               state_q, state_d;
  logic [CNT_W-1:0]         cnt_q;
  logic [1:0]               curve_q;
  logic [TIME_W-1:0]        time_q;
  logic                     rd_en_q;
  logic [CNT_W-1:0]         rd_tag_q;
  logic signed [RATE_W-1:0] lo_q, hi_q, lo0_q, hi0_q, prev_q, rate_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [PRD_W-1:0]  prod_q;
  logic signed [SPREAD_W-1:0] spread_q;
  logic signed [AREA_W-1:0] area_q;
  logic                     m_valid_q;
  logic [OUT_DW-1:0]        m_data_q;

  logic                     in_acc, is_load, ld_ok;
  logic [1:0]               in_curve, curve_clamp;
  logic [4:0]               in_pidx;
  logic signed [RATE_W-1:0] in_pval, rd_data;
  logic [TIME_W-1:0]        in_time;
  logic                     big_t, zero_t;
  logic [4:0]               qi, it_idx;
  logic [13:0]              fr;
  logic [5:0]               lo_k, hi_k;
  logic [CNT_W-1:0]         last_issue, k_run;
  logic                     issue;
  logic signed [32:0]       diff_a, diff_b, tail;
  logic signed [14:0]       fr_s;
  logic signed [PRD_W-1:0]  prod_sh;
  logic signed [RATE_W-1:0] rate_n, rate0_n;
  logic signed [TOT_W-1:0]  total;
  tbl_req_t                 req;
  logic                     out_free;

  assign in_curve = s_axis_tdata_i[1:0];
  assign in_pidx  = s_axis_tdata_i[6:2];
  assign in_pval  = s_axis_tdata_i[38:7];
  assign in_time  = s_axis_tdata_i[57:39];
  assign is_load  = (s_axis_tuser_i[0] == KIND_LOAD);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign ld_ok    = (int'(in_curve) < int'(CURVES)) && (int'(in_pidx) < int'(POINTS));
  assign curve_clamp = (int'(in_curve) >= int'(CURVES)) ? 2'(CURVES - 1) : in_curve;

  assign big_t      = (time_q >= FIVE_Q16);
  assign zero_t     = (time_q == '0);
  assign qi         = time_q[18:14];
  assign fr         = big_t ? 14'd0 : time_q[13:0];
  assign lo_k       = big_t ? 6'd63 : {1'b0, qi};
  assign hi_k       = big_t ? 6'd63 : ({1'b0, qi} + 6'd1);
  assign it_idx     = big_t ? 5'd20 : qi;
  assign last_issue = it_idx + 5'd4;
  assign k_run      = cnt_q - 5'd4;
  assign issue      = (state_q == S_RUN) && (cnt_q <= last_issue);

  always_comb begin
    req       = '0;
    req.we    = in_acc && is_load && ld_ok;
    req.waddr = TBL_AW'(in_curve) * TBL_AW'(POINTS) + TBL_AW'(in_pidx);
    req.wdata = in_pval;
    req.re    = issue;
    unique case (cnt_q)
      5'd0:    req.raddr = addr_of(curve_q, lo_k);
      5'd1:    req.raddr = addr_of(curve_q, hi_k);
      5'd2:    req.raddr = addr_of(2'd0, lo_k);
      5'd3:    req.raddr = addr_of(2'd0, hi_k);
      default: req.raddr = addr_of(curve_q, {1'b0, k_run});
    endcase
  end

  rcii_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rd_data)
  );

  assign fr_s    = signed'({1'b0, fr});
  assign diff_a  = 33'(hi_q) - 33'(lo_q);
  assign diff_b  = 33'(hi0_q) - 33'(lo0_q);
  assign tail    = 33'(rate_q) + 33'(lo_q);
  assign prod_sh = prod_q >>> 14;
  assign rate_n  = zero_t ? '0 : lo_q + RATE_W'(prod_sh);
  assign rate0_n = zero_t ? '0 : lo0_q + RATE_W'(prod_sh);
  assign total   = (TOT_W'(sum_q) <<< 14) + TOT_W'(prod_q);
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = is_load ? S_DONE : S_RUN;
      S_RUN:  if (cnt_q == last_issue + 5'd1) state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_M4;
      S_M4:   state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_en_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_en_q <= issue;
      if (state_q == S_RUN) begin
        cnt_q <= cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q <= cnt_q;
    if (in_acc) begin
      curve_q  <= curve_clamp;
      time_q   <= in_time;
      sum_q    <= '0;
      rate_q   <= '0;
      spread_q <= '0;
      area_q   <= '0;
    end
    if (rd_en_q) begin
      unique case (rd_tag_q)
        5'd0: lo_q  <= rd_data;
        5'd1: hi_q  <= rd_data;
        5'd2: lo0_q <= rd_data;
        5'd3: hi0_q <= rd_data;
        default: begin
          prev_q <= rd_data;
          if (rd_tag_q >= 5'd5) begin
            sum_q <= sum_q + SUM_W'(prev_q) + SUM_W'(rd_data);
          end
        end
      endcase
    end
    unique case (state_q)
      S_M1: prod_q <= PRD_W'(diff_a) * PRD_W'(fr_s);
      S_M2: begin
        rate_q <= rate_n;
        prod_q <= PRD_W'(diff_b) * PRD_W'(fr_s);
      end
      S_M3: begin
        spread_q <= SPREAD_W'(rate0_n) - SPREAD_W'(rate_q);
        prod_q   <= PRD_W'(tail) * PRD_W'(fr_s);
      end
      S_M4: area_q <= AREA_W'(total >>> 17);
      default: ;
    endcase
    if (state_q == S_DONE && out_free) begin
      m_data_q <= {4'd0, spread_q, area_q, rate_q};
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// File: rtl/rcii_checker.sv
// ----------------------------------------------------------------------------
// rcii_checker
// Port-level checks for the rate curve core: output hold and word accounting.
// ----------------------------------------------------------------------------
module rcii_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [rcii_pkg::OUT_DW-1:0]   m_axis_tdata_o
);
  import rcii_pkg::*;

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 2'd0)
    else $error("output word without accepted input");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !s_axis_tready_o)
    else $error("input taken beyond two words in flight");

endmodule

bind rate_curve_interp_integrate_core rcii_checker u_rcii_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: sim/rcii_answer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcii_answer_checker
// Watches both stream channels of the rate curve core. Keeps a private copy of
// the curve points, predicts rate, area and spread for every accepted word,
// and compares each output word with the oldest prediction.
// ----------------------------------------------------------------------------
module rcii_answer_checker #(
  parameter int unsigned POINTS = 23,
  parameter int unsigned CURVES = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [rcii_pkg::IN_DW-1:0]  s_tdata_i,
  input  logic [0:0]                  s_tuser_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [rcii_pkg::OUT_DW-1:0] m_tdata_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          loads_o,
  output int                          dropped_loads_o,
  output int                          queries_o,
  output int                          checked_o
);
  import rcii_pkg::*;

  typedef struct packed {
    logic [SPREAD_W-1:0] spread;
    logic [AREA_W-1:0]   area;
    logic [RATE_W-1:0]   rate;
  } curve_answer_t;

  logic signed [RATE_W-1:0] curve_pts [CURVES*POINTS];
  curve_answer_t            answer_q [$];
  curve_answer_t            want;
  curve_answer_t            got;
  logic [1:0]               in_curve;
  logic [4:0]               in_point;
  logic [RATE_W-1:0]        in_value;
  logic [TIME_W-1:0]        in_time;
  int                       failures;
  int                       loads;
  int                       dropped;
  int                       queries;
  int                       checked;

  function automatic longint grid_pt(int unsigned c, int unsigned k);
    if (k >= POINTS) k = POINTS - 1;
    return longint'(curve_pts[c*POINTS + k]);
  endfunction

  function automatic longint rate_at(int unsigned c, logic [TIME_W-1:0] t);
    int unsigned i;
    longint      f;
    longint      lo;
    longint      hi;
    if (t == '0) return 0;
    if (t >= FIVE_Q16) return grid_pt(c, POINTS - 1);
    i  = t >> 14;
    f  = longint'(t[13:0]);
    lo = grid_pt(c, i);
    hi = grid_pt(c, i + 1);
    return lo + (((hi - lo) * f) >>> 14);
  endfunction

  function automatic longint area_to(int unsigned c, logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] tc;
    int unsigned       i;
    int unsigned       k;
    longint            f;
    longint            acc;
    tc = (t > FIVE_Q16) ? FIVE_Q16 : t;
    if (tc == '0) return 0;
    i   = tc >> 14;
    f   = longint'(tc[13:0]);
    acc = 0;
    for (k = 0; k < i; k++) acc += (grid_pt(c, k) + grid_pt(c, k + 1)) * 16384;
    acc += (rate_at(c, tc) + grid_pt(c, i)) * f;
    return acc >>> 17;
  endfunction

  function automatic curve_answer_t curve_answer(logic [1:0] csel, logic [TIME_W-1:0] t);
    int unsigned   c;
    longint        r;
    longint        a;
    longint        s;
    curve_answer_t ans;
    c = (csel >= CURVES) ? CURVES - 1 : csel;
    r = rate_at(c, t);
    a = area_to(c, t);
    s = rate_at(0, t) - r;
    ans.rate   = r[RATE_W-1:0];
    ans.area   = a[AREA_W-1:0];
    ans.spread = s[SPREAD_W-1:0];
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (curve_pts[n]) curve_pts[n] = ONE_Q24;
      answer_q.delete();
      failures = 0;
      loads    = 0;
      dropped  = 0;
      queries  = 0;
      checked  = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        in_curve = s_tdata_i[1:0];
        in_point = s_tdata_i[6:2];
        in_value = s_tdata_i[38:7];
        in_time  = s_tdata_i[57:39];
        if (s_tuser_i[0] == KIND_LOAD) begin
          loads++;
          if (in_curve < CURVES && in_point < POINTS) begin
            curve_pts[in_curve*POINTS + in_point] = in_value;
          end else begin
            dropped++;
          end
          answer_q.push_back('0);
        end else begin
          queries++;
          answer_q.push_back(curve_answer(in_curve, in_time));
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[SPREAD_W+AREA_W+RATE_W-1:0];
        if (answer_q.size() == 0) begin
          failures++;
          if (failures <= 10) $display("%0t: output word with nothing pending: %h", $time, got);
        end else begin
          want = answer_q.pop_front();
          checked++;
          if (got !== want || m_tdata_i[OUT_DW-1:SPREAD_W+AREA_W+RATE_W] !== '0) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: word %0d mismatch", $time, checked);
              $display("  rate   want %h got %h", want.rate, got.rate);
              $display("  area   want %h got %h", want.area, got.area);
              $display("  spread want %h got %h", want.spread, got.spread);
            end
          end
        end
      end
    end
    fail_count_o    <= failures;
    pending_o       <= answer_q.size();
    loads_o         <= loads;
    dropped_loads_o <= dropped;
    queries_o       <= queries;
    checked_o       <= checked;
  end

endmodule

// File: sim/tb_rate_curve_interp_integrate_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rate_curve_interp_integrate_core
// Drives point loads and rate/area/spread queries into the rate curve core
// with bursty input and a stalling output side; the answer checker beside
// the core predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_rate_curve_interp_integrate_core;
  import rcii_pkg::*;

  localparam int unsigned POINTS       = 23;
  localparam int unsigned CURVES       = 3;
  localparam int          RANDOM_ITEMS = 1300;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          SETTLE       = 40;

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_DW-1:0]  s_tdata  = '0;
  logic [0:0]        s_tuser  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;

  int fail_count;
  int pending;
  int loads;
  int dropped_loads;
  int queries;
  int checked;
  int cycles      = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  bit steady      = 1'b0;

  always #6 clk_i = ~clk_i;

  rate_curve_interp_integrate_core #(
    .POINTS(POINTS),
    .CURVES(CURVES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  rcii_answer_checker #(
    .POINTS(POINTS),
    .CURVES(CURVES)
  ) u_answer_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .s_tuser_i      (s_tuser),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .loads_o        (loads),
    .dropped_loads_o(dropped_loads),
    .queries_o      (queries),
    .checked_o      (checked)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: always ready, coin flip, or long stalls, switching now and then
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_stall     = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(50, 300);
      end
      rx_mode_left--;
      case (rx_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
          end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall = $urandom_range(1, 30);
          end
        end
      endcase
    end
  end

  task automatic pace();
    items_sent++;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    s_tvalid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
    burst_left = $urandom_range(0, 23);
  endtask

  task automatic push_word(logic kind, logic [1:0] csel, logic [4:0] pidx,
                           logic [RATE_W-1:0] val, logic [TIME_W-1:0] t);
    s_tuser  <= kind;
    s_tdata  <= {6'd0, t, val, pidx, csel};
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pace();
  endtask

  task automatic load_pt(logic [1:0] csel, logic [4:0] pidx, logic [RATE_W-1:0] val);
    push_word(KIND_LOAD, csel, pidx, val, TIME_W'($urandom_range(0, 524287)));
  endtask

  task automatic ask(logic [1:0] csel, logic [TIME_W-1:0] t);
    push_word(KIND_QUERY, csel, 5'($urandom_range(0, 31)), $urandom, t);
  endtask

  // hold input idle until every predicted word has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [RATE_W-1:0] rand_rate();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(0, 6710886) - 3355443;
    if (pick < 85) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return ONE_Q24;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    int unsigned pick;
    int unsigned q;
    pick = $urandom_range(0, 99);
    if (pick < 70) return TIME_W'($urandom_range(1, FIVE_Q16 - 1));
    if (pick < 80) begin
      q = $urandom_range(0, 20) * 16384;
      return TIME_W'(q + $urandom_range(0, 2) - ((q == 0) ? 0 : 1));
    end
    if (pick < 90) return TIME_W'($urandom_range(FIVE_Q16, 524287));
    if (pick < 95) return '0;
    return FIVE_Q16;
  endfunction

  initial begin
    int unsigned pick;
    int unsigned c;
    int unsigned first_pt;
    int unsigned n;
    int          directed;
    bit          drained_mid;

    drained_mid = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset contents, then extremes, dropped loads and boundary times
    ask(2'd0, '0);
    ask(2'd1, 19'd40000);
    ask(2'd2, FIVE_Q16);
    ask(2'd3, 19'h7FFFF);
    load_pt(2'd0, 5'd0, 32'h7FFF_FFFF);
    load_pt(2'd0, 5'd22, 32'h8000_0000);
    load_pt(2'd1, 5'd0, 32'h8000_0000);
    load_pt(2'd1, 5'd22, 32'h7FFF_FFFF);
    load_pt(2'd2, 5'd10, 32'hFFFF_FFFF);
    load_pt(2'd3, 5'd5, 32'h1234_5678);
    load_pt(2'd1, 5'd23, 32'h0BAD_0BAD);
    load_pt(2'd2, 5'd31, 32'h0BAD_0BAD);
    load_pt(2'd0, 5'd21, 32'h0000_0000);
    load_pt(2'd2, 5'd16, 32'h8000_0000);
    ask(2'd0, 19'd16383);
    ask(2'd1, 19'd16384);
    ask(2'd1, 19'd1);
    ask(2'd0, FIVE_Q16 - 19'd1);
    ask(2'd0, FIVE_Q16);
    ask(2'd1, FIVE_Q16 + 19'd1);
    ask(2'd2, 19'h7FFFF);
    ask(2'd3, 19'd200000);
    ask(2'd2, 19'd180224);
    directed = items_sent;
    drain();

    while (items_sent < directed + RANDOM_ITEMS) begin
      if (!drained_mid && items_sent >= directed + 600) begin
        drain();
        drained_mid = 1'b1;
      end
      steady = (items_sent >= directed + 800 && items_sent < directed + 950);
      pick   = $urandom_range(0, 99);
      if (pick < 45) begin
        c        = $urandom_range(0, CURVES - 1);
        first_pt = $urandom_range(0, POINTS - 1);
        n        = $urandom_range(1, 8);
        for (int unsigned j = 0; j < n && first_pt + j < POINTS; j++) begin
          load_pt(2'(c), 5'(first_pt + j), rand_rate());
        end
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) ask(2'($urandom_range(0, 3)), rand_time());
          else ask(2'(c), rand_time());
        end
      end else if (pick < 85) begin
        ask(2'($urandom_range(0, CURVES - 1)), rand_time());
      end else if (pick < 93) begin
        load_pt(2'($urandom_range(0, CURVES - 1)), 5'($urandom_range(0, POINTS - 1)),
                rand_rate());
      end else begin
        case ($urandom_range(0, 2))
          0: load_pt(2'd3, 5'($urandom_range(0, 31)), $urandom);
          1: load_pt(2'($urandom_range(0, 3)), 5'($urandom_range(POINTS, 31)), $urandom);
          default: ask(2'd3, rand_time());
        endcase
      end
    end
    steady = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d loads (%0d outside the table) and %0d queries on all curves",
             loads, dropped_loads, queries);
    $display("%0d result words checked, %0d failures", checked, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
